@@ hw/rtl/lae_pkg.sv @@
package lae_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_RETRY = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_ERROR = 2'd3
    } t_status;

    // Cache outcome codes carried with each word
    localparam logic [1:0] CACHE_HIT   = 2'd0;
    localparam logic [1:0] CACHE_BUSY  = 2'd1;
    localparam logic [1:0] CACHE_MISS  = 2'd2;
    localparam logic [1:0] CACHE_RANGE = 2'd3;

    // Load opcodes
    localparam logic [3:0] OP_LDRB  = 4'd0;
    localparam logic [3:0] OP_LDRH  = 4'd1;
    localparam logic [3:0] OP_LDRW  = 4'd2;
    localparam logic [3:0] OP_LDR   = 4'd3;
    localparam logic [3:0] OP_LDRSB = 4'd4;
    localparam logic [3:0] OP_LDRSH = 4'd5;
    localparam logic [3:0] OP_LDRSW = 4'd6;
    localparam logic [3:0] OP_LDREX = 4'd7;
    localparam logic [3:0] OP_VLDRB = 4'd8;
    localparam logic [3:0] OP_VLDRH = 4'd9;
    localparam logic [3:0] OP_VLDRS = 4'd10;
    localparam logic [3:0] OP_VLDRD = 4'd11;
    localparam logic [3:0] OP_VLDRQ = 4'd12;

    // Index extension modes
    localparam logic [3:0] EXT_UXTB = 4'd8;
    localparam logic [3:0] EXT_UXTH = 4'd9;
    localparam logic [3:0] EXT_UXTW = 4'd10;
    localparam logic [3:0] EXT_UXTX = 4'd11;
    localparam logic [3:0] EXT_SXTB = 4'd12;
    localparam logic [3:0] EXT_SXTH = 4'd13;
    localparam logic [3:0] EXT_SXTW = 4'd14;
    localparam logic [3:0] EXT_SXTX = 4'd15;

    // Access size, log2 of bytes
    localparam logic [2:0] SIZE_B = 3'd0;
    localparam logic [2:0] SIZE_H = 3'd1;
    localparam logic [2:0] SIZE_W = 3'd2;
    localparam logic [2:0] SIZE_D = 3'd3;
    localparam logic [2:0] SIZE_Q = 3'd4;

    // Control and status handed from the load formatter to the top level
    typedef struct packed {
        t_status    status;
        logic [2:0] size_log;
        logic       dest_write;
        logic       base_write;
    } t_load_ctl;

endpackage

@@ hw/rtl/lae_agu.sv @@
module lae_agu (
    input  logic [31:0] i_base_address,
    input  logic [63:0] i_index_value,
    input  logic [2:0]  i_shift_amount,
    input  logic [3:0]  i_extend_mode,
    input  logic        i_add_offset,
    input  logic        i_pre_index,
    output logic [31:0] o_access_address,
    output logic [31:0] o_base_value
);
    import lae_pkg::*;

    logic [31:0] ext;
    logic [31:0] off;
    logic [31:0] soff;

    // Only the low 32 bits of the extended, shifted index reach the adder
    always_comb begin
        case (i_extend_mode)
            EXT_UXTB: ext = {24'd0, i_index_value[7:0]};
            EXT_UXTH: ext = {16'd0, i_index_value[15:0]};
            EXT_SXTB: ext = {{24{i_index_value[7]}}, i_index_value[7:0]};
            EXT_SXTH: ext = {{16{i_index_value[15]}}, i_index_value[15:0]};
            default:  ext = i_index_value[31:0];
        endcase
        if (i_extend_mode inside {[EXT_UXTB:EXT_SXTX]}) begin
            off = ext << i_shift_amount;
        end else begin
            off = i_index_value[31:0];
        end
        soff = i_add_offset ? off : (32'd0 - off);
    end

    assign o_base_value     = i_base_address + soff;
    assign o_access_address = i_pre_index ? o_base_value : i_base_address;

endmodule

@@ hw/rtl/lae_fmt.sv @@
module lae_fmt (
    input  logic [3:0]        i_opcode,
    input  logic [1:0]        i_cache_outcome,
    input  logic              i_update_base,
    input  logic              i_dest_present,
    input  logic [63:0]       i_load_low,
    input  logic [63:0]       i_load_high,
    output lae_pkg::t_load_ctl o_ctl,
    output logic [63:0]       o_dest_low,
    output logic [63:0]       o_dest_high
);
    import lae_pkg::*;

    logic        legal;
    logic [2:0]  size_log;
    logic [63:0] data;
    logic        dw;

    always_comb begin
        legal = 1'b1;
        case (i_opcode)
            OP_LDRB, OP_LDRSB, OP_VLDRB:           size_log = SIZE_B;
            OP_LDRH, OP_LDRSH, OP_VLDRH:           size_log = SIZE_H;
            OP_LDRW, OP_LDRSW, OP_LDREX, OP_VLDRS: size_log = SIZE_W;
            OP_LDR, OP_VLDRD:                      size_log = SIZE_D;
            OP_VLDRQ:                              size_log = SIZE_Q;
            default: begin
                size_log = SIZE_B;
                legal    = 1'b0;
            end
        endcase

        // Mask to the access size, sign-extend the signed scalar loads
        case (i_opcode)
            OP_LDRB, OP_VLDRB:           data = {56'd0, i_load_low[7:0]};
            OP_LDRH, OP_VLDRH:           data = {48'd0, i_load_low[15:0]};
            OP_LDRW, OP_LDREX, OP_VLDRS: data = {32'd0, i_load_low[31:0]};
            OP_LDRSB: data = {{56{i_load_low[7]}}, i_load_low[7:0]};
            OP_LDRSH: data = {{48{i_load_low[15]}}, i_load_low[15:0]};
            OP_LDRSW: data = {{32{i_load_low[31]}}, i_load_low[31:0]};
            default:  data = i_load_low;
        endcase

        dw = legal && (i_cache_outcome == CACHE_HIT) && i_dest_present;

        o_ctl.status     = legal ? t_status'(i_cache_outcome) : STAT_ERROR;
        o_ctl.size_log   = size_log;
        o_ctl.dest_write = dw;
        o_ctl.base_write = legal && i_update_base &&
                           ((i_cache_outcome == CACHE_HIT) ||
                            (i_cache_outcome == CACHE_MISS));
        o_dest_low  = dw ? data : 64'd0;
        o_dest_high = (dw && (i_opcode == OP_VLDRQ)) ? i_load_high : 64'd0;
    end

endmodule

@@ hw/rtl/load_address_and_extend_unit_top.sv @@
// Load address generation and extension unit.
//
// Command channel: drive the load word on the i_ ports and raise start; the
// word is taken at the rising edge where start is high and busy is low.
// busy is low whenever the unit is out of reset, so a new word may follow
// in every cycle.
//
// Result channel: each accepted word gives exactly one result word, shown
// for one cycle with o_valid high. The receiver cannot stall the unit and
// must take the result in that cycle.
//
// Pipeline: the word is captured in an input register when it is accepted,
// address add and data formatting run in one combinational pass, and the
// result register loads from that pass and raises o_valid. Throughput is
// one word per cycle while out of reset, set by that single adder-plus-mux
// pass.
//
// Reset: i_rst_n is synchronous and active low. It clears the valid bits
// of both stages; words in flight are dropped and busy is high during it.
module load_address_and_extend_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_base_address,
    input  logic [63:0] i_index_value,
    input  logic [2:0]  i_shift_amount,
    input  logic [3:0]  i_extend_mode,
    input  logic        i_add_offset,
    input  logic        i_pre_index,
    input  logic        i_update_base,
    input  logic [3:0]  i_opcode,
    input  logic [1:0]  i_cache_outcome,
    input  logic [63:0] i_load_low,
    input  logic [63:0] i_load_high,
    input  logic        i_dest_present,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_access_address,
    output logic [2:0]  o_access_size_log,
    output logic        o_dest_write,
    output logic [63:0] o_dest_low,
    output logic [63:0] o_dest_high,
    output logic        o_base_write,
    output logic [31:0] o_base_value
);
    import lae_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic [31:0] r_base_address;
    logic [63:0] r_index_value;
    logic [2:0]  r_shift_amount;
    logic [3:0]  r_extend_mode;
    logic        r_add_offset;
    logic        r_pre_index;
    logic        r_update_base;
    logic [3:0]  r_opcode;
    logic [1:0]  r_cache_outcome;
    logic [63:0] r_load_low;
    logic [63:0] r_load_high;
    logic        r_dest_present;

    // Result stage
    logic        r_valid;
    logic [1:0]  r_status;
    logic [31:0] r_access_address;
    logic [2:0]  r_access_size_log;
    logic        r_dest_write;
    logic [63:0] r_dest_low;
    logic [63:0] r_dest_high;
    logic        r_base_write;
    logic [31:0] r_base_value;

    logic        accept;
    logic [31:0] n_access_address;
    logic [31:0] n_base_value;
    t_load_ctl   n_ctl;
    logic [63:0] n_dest_low;
    logic [63:0] n_dest_high;

    // Hold off commands only while reset is applied
    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // Capture the payload only on an accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base_address  <= i_base_address;
            r_index_value   <= i_index_value;
            r_shift_amount  <= i_shift_amount;
            r_extend_mode   <= i_extend_mode;
            r_add_offset    <= i_add_offset;
            r_pre_index     <= i_pre_index;
            r_update_base   <= i_update_base;
            r_opcode        <= i_opcode;
            r_cache_outcome <= i_cache_outcome;
            r_load_low      <= i_load_low;
            r_load_high     <= i_load_high;
            r_dest_present  <= i_dest_present;
        end
    end

    lae_agu u_agu (
        .i_base_address   (r_base_address),
        .i_index_value    (r_index_value),
        .i_shift_amount   (r_shift_amount),
        .i_extend_mode    (r_extend_mode),
        .i_add_offset     (r_add_offset),
        .i_pre_index      (r_pre_index),
        .o_access_address (n_access_address),
        .o_base_value     (n_base_value)
    );

    lae_fmt u_fmt (
        .i_opcode        (r_opcode),
        .i_cache_outcome (r_cache_outcome),
        .i_update_base   (r_update_base),
        .i_dest_present  (r_dest_present),
        .i_load_low      (r_load_low),
        .i_load_high     (r_load_high),
        .o_ctl           (n_ctl),
        .o_dest_low      (n_dest_low),
        .o_dest_high     (n_dest_high)
    );

    // Advance the result stage; the strobe lasts one cycle per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_status          <= n_ctl.status;
            r_access_address  <= n_access_address;
            r_access_size_log <= n_ctl.size_log;
            r_dest_write      <= n_ctl.dest_write;
            r_dest_low        <= n_dest_low;
            r_dest_high       <= n_dest_high;
            r_base_write      <= n_ctl.base_write;
            r_base_value      <= n_base_value;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_access_address  = r_access_address;
    assign o_access_size_log = r_access_size_log;
    assign o_dest_write      = r_dest_write;
    assign o_dest_low        = r_dest_low;
    assign o_dest_high       = r_dest_high;
    assign o_base_write      = r_base_write;
    assign o_base_value      = r_base_value;

endmodule

@@ hw/rtl/lae_chk.sv @@
module lae_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [2:0]  o_access_size_log,
    input logic        o_dest_write,
    input logic [63:0] o_dest_low,
    input logic [63:0] o_dest_high,
    input logic        o_base_write
);
    import lae_pkg::*;

    // Each accepted word shows its result once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after accept");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_valid)
        else $error("result without accepted word");

    // Data lanes are zero unless the destination is written
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dest_write) |-> (o_dest_low == 64'd0 && o_dest_high == 64'd0))
        else $error("data driven without destination write");

    // Writes only follow a hit or an enqueued miss
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_dest_write || o_base_write)) |->
        (o_status == STAT_DONE || o_status == STAT_MISS) &&
        (!o_dest_write || o_status == STAT_DONE))
        else $error("register write with failing status");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_access_size_log <= SIZE_Q) &&
        (o_dest_high == 64'd0 || o_access_size_log == SIZE_Q))
        else $error("bad access size or stray high data");

endmodule

bind load_address_and_extend_unit_top lae_chk u_lae_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_status          (o_status),
    .o_access_size_log (o_access_size_log),
    .o_dest_write      (o_dest_write),
    .o_dest_low        (o_dest_low),
    .o_dest_high       (o_dest_high),
    .o_base_write      (o_base_write)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lae_pkg::*;

    localparam int RANDOM_WORDS = 1400;
    localparam int QUIET_FIRST  = 500;   // first random word of the stretch with no gaps
    localparam int QUIET_LAST   = 799;   // last random word of that stretch
    localparam int DRAIN_CYCLES = 8;     // extra edges to watch for strays once nothing is pending
    localparam int CYCLE_LIMIT  = 100000;
    localparam int REPORT_MAX   = 10;

    // One load word as it stands on the command ports.
    typedef struct packed {
        logic [31:0] base_address;
        logic [63:0] index_value;
        logic [2:0]  shift_amount;
        logic [3:0]  extend_mode;
        logic        add_offset;
        logic        pre_index;
        logic        update_base;
        logic [3:0]  opcode;
        logic [1:0]  cache_outcome;
        logic [63:0] load_low;
        logic [63:0] load_high;
        logic        dest_present;
    } t_load_word;

    // One result word as it stands on the result ports.
    typedef struct packed {
        t_status     status;
        logic [31:0] access_address;
        logic [2:0]  access_size_log;
        logic        dest_write;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic        base_write;
        logic [31:0] base_value;
    } t_load_result;

    // Scoreboard: predict every accepted load word and match results in order.
    class t_load_scoreboard;
        t_load_result expected_results[$];
        int mismatches;
        int checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // Work out address, size, status, write enables and formatted data.
        function t_load_result predict_load(t_load_word w);
            logic [63:0] ext_index;
            logic [31:0] offset;
            logic [63:0] mask_lo;
            logic [63:0] mask_hi;
            logic [63:0] data;
            t_load_result r;
            r       = '0;
            mask_lo = '0;
            mask_hi = '0;

            // Extend the index; unlisted modes pass it through with no shift.
            case (w.extend_mode)
                EXT_UXTB: ext_index = {56'd0, w.index_value[7:0]};
                EXT_UXTH: ext_index = {48'd0, w.index_value[15:0]};
                EXT_UXTW: ext_index = {32'd0, w.index_value[31:0]};
                EXT_SXTB: ext_index = {{56{w.index_value[7]}}, w.index_value[7:0]};
                EXT_SXTH: ext_index = {{48{w.index_value[15]}}, w.index_value[15:0]};
                EXT_SXTW: ext_index = {{32{w.index_value[31]}}, w.index_value[31:0]};
                default:  ext_index = w.index_value;
            endcase
            if (w.extend_mode >= EXT_UXTB)
                ext_index = ext_index << w.shift_amount;

            // Only the low half takes part; the sum wraps at 32 bits.
            offset = ext_index[31:0];
            if (!w.add_offset)
                offset = 32'd0 - offset;
            r.base_value     = w.base_address + offset;
            r.access_address = w.pre_index ? r.base_value : w.base_address;

            case (w.opcode)
                OP_LDRB, OP_LDRSB, OP_VLDRB: begin
                    r.access_size_log = SIZE_B;
                    mask_lo = 64'h0000_0000_0000_00ff;
                end
                OP_LDRH, OP_LDRSH, OP_VLDRH: begin
                    r.access_size_log = SIZE_H;
                    mask_lo = 64'h0000_0000_0000_ffff;
                end
                OP_LDRW, OP_LDRSW, OP_LDREX, OP_VLDRS: begin
                    r.access_size_log = SIZE_W;
                    mask_lo = 64'h0000_0000_ffff_ffff;
                end
                OP_LDR, OP_VLDRD: begin
                    r.access_size_log = SIZE_D;
                    mask_lo = '1;
                end
                OP_VLDRQ: begin
                    r.access_size_log = SIZE_Q;
                    mask_lo = '1;
                    mask_hi = '1;
                end
                default: r.access_size_log = SIZE_B;
            endcase

            if (w.opcode > OP_VLDRQ) begin
                r.status = STAT_ERROR;
            end else begin
                r.status = t_status'(w.cache_outcome);
                if (w.cache_outcome == CACHE_HIT) begin
                    data = w.load_low & mask_lo;
                    case (w.opcode)
                        OP_LDRSB: data = {{56{data[7]}}, data[7:0]};
                        OP_LDRSH: data = {{48{data[15]}}, data[15:0]};
                        OP_LDRSW: data = {{32{data[31]}}, data[31:0]};
                        default: ;
                    endcase
                    r.dest_write = w.dest_present;
                    r.base_write = w.update_base;
                    if (w.dest_present) begin
                        r.dest_low  = data;
                        r.dest_high = w.load_high & mask_hi;
                    end
                end else if (w.cache_outcome == CACHE_MISS) begin
                    r.base_write = w.update_base;
                end
            end
            return r;
        endfunction

        function void note_word(t_load_word w);
            expected_results.push_back(predict_load(w));
        endfunction

        function void check_result(t_load_result got);
            t_load_result exp;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with nothing pending: status=%0d addr=%h base=%h",
                             got.status, got.access_address, got.base_value);
                return;
            end
            exp = expected_results.pop_front();
            checked++;
            if (got != exp) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch on result %0d", checked);
                    $display("  exp st=%0d a=%h sz=%0d dw=%b lo=%h hi=%h bw=%b b=%h",
                             exp.status, exp.access_address, exp.access_size_log,
                             exp.dest_write, exp.dest_low, exp.dest_high,
                             exp.base_write, exp.base_value);
                    $display("  got st=%0d a=%h sz=%0d dw=%b lo=%h hi=%h bw=%b b=%h",
                             got.status, got.access_address, got.access_size_log,
                             got.dest_write, got.dest_low, got.dest_high,
                             got.base_write, got.base_value);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_base_address;
    logic [63:0] i_index_value;
    logic [2:0]  i_shift_amount;
    logic [3:0]  i_extend_mode;
    logic        i_add_offset;
    logic        i_pre_index;
    logic        i_update_base;
    logic [3:0]  i_opcode;
    logic [1:0]  i_cache_outcome;
    logic [63:0] i_load_low;
    logic [63:0] i_load_high;
    logic        i_dest_present;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_access_address;
    logic [2:0]  o_access_size_log;
    logic        o_dest_write;
    logic [63:0] o_dest_low;
    logic [63:0] o_dest_high;
    logic        o_base_write;
    logic [31:0] o_base_value;

    t_load_scoreboard sb;

    load_address_and_extend_unit_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_base_address    (i_base_address),
        .i_index_value     (i_index_value),
        .i_shift_amount    (i_shift_amount),
        .i_extend_mode     (i_extend_mode),
        .i_add_offset      (i_add_offset),
        .i_pre_index       (i_pre_index),
        .i_update_base     (i_update_base),
        .i_opcode          (i_opcode),
        .i_cache_outcome   (i_cache_outcome),
        .i_load_low        (i_load_low),
        .i_load_high       (i_load_high),
        .i_dest_present    (i_dest_present),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_access_address  (o_access_address),
        .o_access_size_log (o_access_size_log),
        .o_dest_write      (o_dest_write),
        .o_dest_low        (o_dest_low),
        .o_dest_high       (o_dest_high),
        .o_base_write      (o_base_write),
        .o_base_value      (o_base_value)
    );

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: fail the run if it has not finished by CYCLE_LIMIT.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("load_address_and_extend_unit_top regression: fail");
        $finish;
    end

    // Watch both channels at the edge: the values read here are the ones the
    // unit samples, since every driver updates through nonblocking writes.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_word({i_base_address, i_index_value, i_shift_amount, i_extend_mode,
                          i_add_offset, i_pre_index, i_update_base, i_opcode,
                          i_cache_outcome, i_load_low, i_load_high, i_dest_present});
        end
        if (o_valid) begin
            sb.check_result({t_status'(o_status), o_access_address, o_access_size_log,
                             o_dest_write, o_dest_low, o_dest_high, o_base_write,
                             o_base_value});
        end
    end

    // Random load word. Bias toward legal opcodes and listed extend modes,
    // keep a share of illegal opcodes, unlisted modes and shifts past four.
    function automatic t_load_word rand_word();
        t_load_word w;
        w.base_address = 32'($urandom);
        case ($urandom_range(3))
            0:       w.index_value = 64'($urandom_range(255));
            1:       w.index_value = '1 - 64'($urandom_range(255));
            default: w.index_value = {32'($urandom), 32'($urandom)};
        endcase
        if ($urandom_range(9) == 0)
            w.shift_amount = 3'($urandom_range(7, 5));
        else
            w.shift_amount = 3'($urandom_range(4));
        if ($urandom_range(5) == 0)
            w.extend_mode = 4'($urandom_range(7));
        else
            w.extend_mode = 4'($urandom_range(15, 8));
        if ($urandom_range(9) == 0)
            w.opcode = 4'($urandom_range(15, 13));
        else
            w.opcode = 4'($urandom_range(12));
        // Most words hit, so the data path sees plenty of traffic.
        w.cache_outcome = $urandom_range(1) ? CACHE_HIT : 2'($urandom_range(3));
        w.add_offset    = 1'($urandom_range(1));
        w.pre_index     = 1'($urandom_range(1));
        w.update_base   = 1'($urandom_range(1));
        w.dest_present  = 1'($urandom_range(1));
        w.load_low      = {32'($urandom), 32'($urandom)};
        w.load_high     = {32'($urandom), 32'($urandom)};
        return w;
    endfunction

    // Present one word and hold it until the unit takes it. Call at an edge.
    task automatic send_word(input t_load_word w);
        i_base_address  <= w.base_address;
        i_index_value   <= w.index_value;
        i_shift_amount  <= w.shift_amount;
        i_extend_mode   <= w.extend_mode;
        i_add_offset    <= w.add_offset;
        i_pre_index     <= w.pre_index;
        i_update_base   <= w.update_base;
        i_opcode        <= w.opcode;
        i_cache_outcome <= w.cache_outcome;
        i_load_low      <= w.load_low;
        i_load_high     <= w.load_high;
        i_dest_present  <= w.dest_present;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start for a random number of cycles, about a quarter of the time.
    task automatic idle_gap(input bit allow);
        if (allow) begin
            while ($urandom_range(99) < 25) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    initial begin
        t_load_word w;
        sb = new();

        // Hold every input at a known value and keep the unit in reset.
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_base_address  <= '0;
        i_index_value   <= '0;
        i_shift_amount  <= '0;
        i_extend_mode   <= '0;
        i_add_offset    <= 1'b0;
        i_pre_index     <= 1'b0;
        i_update_base   <= 1'b0;
        i_opcode        <= OP_LDRB;
        i_cache_outcome <= CACHE_HIT;
        i_load_low      <= '0;
        i_load_high     <= '0;
        i_dest_present  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every legal opcode on a hit, with the sign bits of byte, half and
        // word set on odd passes and clear on even ones. The extend mode walks
        // through the unlisted codes and the first listed ones.
        for (int i = 0; i <= int'(OP_VLDRQ); i++) begin
            w = rand_word();
            w.opcode        = 4'(i);
            w.extend_mode   = 4'(i);
            w.shift_amount  = 3'(i % 8);
            w.cache_outcome = CACHE_HIT;
            w.dest_present  = 1'b1;
            w.update_base   = 1'(i % 2);
            w.add_offset    = 1'((i / 2) % 2);
            w.pre_index     = 1'((i / 4) % 2);
            if (i % 2)
                w.load_low = w.load_low | 64'h0000_0000_8000_8080;
            else
                w.load_low = w.load_low & ~64'h0000_0000_8000_8080;
            send_word(w);
        end

        // Illegal opcodes: outcome ignored; cover the remaining extend modes
        // and the shifts past four at the same time.
        for (int i = 13; i <= 15; i++) begin
            w = rand_word();
            w.opcode        = 4'(i);
            w.extend_mode   = 4'(i);
            w.shift_amount  = 3'(i - 8);
            w.cache_outcome = 2'(i % 4);
            w.update_base   = 1'b1;
            w.dest_present  = 1'b1;
            send_word(w);
        end

        // Each cache outcome on a plain doubleword load with both writes asked.
        for (int k = 0; k < 4; k++) begin
            w = rand_word();
            w.opcode        = OP_LDR;
            w.cache_outcome = 2'(k);
            w.update_base   = 1'b1;
            w.dest_present  = 1'b1;
            send_word(w);
        end

        // Field extremes: address wrap both ways, all-zero and all-one data.
        w = rand_word();
        w.base_address  = '1;
        w.index_value   = '1;
        w.extend_mode   = EXT_SXTX;
        w.shift_amount  = 3'd4;
        w.add_offset    = 1'b1;
        w.pre_index     = 1'b1;
        w.opcode        = OP_VLDRQ;
        w.cache_outcome = CACHE_HIT;
        w.dest_present  = 1'b1;
        w.load_low      = '1;
        w.load_high     = '1;
        send_word(w);
        w.base_address  = '0;
        w.add_offset    = 1'b0;
        w.extend_mode   = EXT_UXTX;
        w.shift_amount  = 3'd0;
        w.opcode        = OP_LDRSW;
        send_word(w);
        w.index_value   = '0;
        w.load_low      = '0;
        w.load_high     = '0;
        w.opcode        = OP_LDRSB;
        send_word(w);
        w.dest_present  = 1'b0;
        w.update_base   = 1'b1;
        w.opcode        = OP_VLDRQ;
        w.load_low      = '1;
        w.load_high     = '1;
        send_word(w);

        // Random words; leave one long stretch back to back.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            idle_gap(n < QUIET_FIRST || n > QUIET_LAST);
            send_word(rand_word());
        end
        start <= 1'b0;

        // Wait for the last results, then keep watching for stray results.
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d load results: all opcodes, extend modes, shifts and outcomes",
                 sb.checked);
        $display("%0d mismatching results, %0d still pending",
                 sb.mismatches, sb.expected_results.size());
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("load_address_and_extend_unit_top regression: pass");
        end else begin
            $display("load_address_and_extend_unit_top regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/lae_pkg.sv
hw/rtl/lae_agu.sv
hw/rtl/lae_fmt.sv
hw/rtl/load_address_and_extend_unit_top.sv
hw/rtl/lae_chk.sv
tb/sv/tb_top.sv
